[src/ovl_pkg.sv]
// Shared types and constants for the ordered value list.
// Opcode and status codes, field widths and the sign extension helper.
// No dependencies.
package ovl_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int TOTAL_W = 36;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_SUM    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // sign-extend one stored value to the running total width
  function automatic logic [TOTAL_W-1:0] sext_total(input logic [VALUE_W-1:0] v);
    sext_total = {{(TOTAL_W-VALUE_W){v[VALUE_W-1]}}, v};
  endfunction

endpackage

[src/ovl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ovl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ordered_value_list.sv]
// Ordered value list: append, ordered insert, delete first match, sum query.
// Append and sum need no scan; insert and delete scan the entry RAM one read
// per cycle when the list is not empty (for insert, also not full). One
// request at a time; the result register frees the output.
// Synchronous active-low reset clears the entry count, the total, the FSM and out_valid.
// Depends on ovl_pkg and ovl_ram.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic signed [VALUE_W-1:0] in_operand_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [COUNT_W-1:0]        out_entry_count,
  output logic signed [TOTAL_W-1:0] out_list_total
);

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FINISH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  opcode_t               op_r, op_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  logic [VALUE_W-1:0]    carry_r, carry_nxt;
  logic                  hit_r, hit_nxt;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]    sum_r, sum_nxt;
  logic [IW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  data_vld_r, data_vld_nxt;
  logic [AW-1:0]         data_idx_r, data_idx_nxt;
  status_t               status_r, status_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0]    out_total_r, out_total_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;
  logic                  list_full;

  ovl_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign list_full = (cnt_r == IW'(CAPACITY));
  assign in_stall  = (state_r != S_IDLE);

  // Sequencer. Writes during a scan always trail the reads, so a read never
  // meets an entry already rewritten by the same request.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    carry_nxt      = carry_r;
    hit_nxt        = hit_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    rd_idx_nxt     = rd_idx_r;
    data_vld_nxt   = data_vld_r;
    data_idx_nxt   = data_idx_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_total_nxt  = out_total_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = rd_idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = opcode_t'(in_opcode);
          val_nxt      = in_operand_value;
          carry_nxt    = in_operand_value;
          hit_nxt      = 1'b0;
          rd_idx_nxt   = '0;
          data_vld_nxt = 1'b0;
          status_nxt   = ST_DONE;
          state_nxt    = S_EMIT;
          case (opcode_t'(in_opcode))
            OP_APPEND, OP_INSERT: begin
              if (list_full) begin
                status_nxt = ST_FULL;
              end else if (opcode_t'(in_opcode) == OP_APPEND || cnt_r == '0) begin
                // tail write needs no scan
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_operand_value;
                cnt_nxt   = cnt_r + IW'(1);
                sum_nxt   = sum_r + sext_total(in_operand_value);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_MISSING;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // read issue: one entry per cycle up to the count
        if (rd_idx_r < cnt_r) begin
          ram_re       = 1'b1;
          rd_idx_nxt   = rd_idx_r + IW'(1);
          data_vld_nxt = 1'b1;
          data_idx_nxt = rd_idx_r[AW-1:0];
        end else begin
          data_vld_nxt = 1'b0;
        end
        // process the entry read last cycle
        if (data_vld_r) begin
          if (op_r == OP_INSERT) begin
            // from the first entry not less than the value, ripple a carry
            if (hit_r || ($signed(ram_rdata) >= $signed(val_r))) begin
              ram_we    = 1'b1;
              ram_waddr = data_idx_r;
              ram_wdata = carry_r;
              carry_nxt = ram_rdata;
              hit_nxt   = 1'b1;
            end
          end else begin
            // after the match, move each entry down one slot
            if (hit_r) begin
              ram_we    = 1'b1;
              ram_waddr = data_idx_r - AW'(1);
              ram_wdata = ram_rdata;
            end else if (ram_rdata == val_r) begin
              hit_nxt = 1'b1;
            end
          end
          if (IW'(data_idx_r) == cnt_r - IW'(1)) begin
            data_vld_nxt = 1'b0;
            state_nxt    = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (op_r == OP_INSERT) begin
          // carry lands in the new tail slot
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = carry_r;
          cnt_nxt   = cnt_r + IW'(1);
          sum_nxt   = sum_r + sext_total(val_r);
        end else if (hit_r) begin
          cnt_nxt = cnt_r - IW'(1);
          sum_nxt = sum_r - sext_total(val_r);
        end else begin
          status_nxt = ST_MISSING;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = COUNT_W'(cnt_r);
          out_total_nxt  = sum_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      hit_r       <= 1'b0;
      data_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      hit_r       <= hit_nxt;
      data_vld_r  <= data_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    carry_r      <= carry_nxt;
    rd_idx_r     <= rd_idx_nxt;
    data_idx_r   <= data_idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_list_total  = out_total_r;

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted request did not leave idle");

  // the count stays within the list capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IW'(CAPACITY))
    else $error("entry count above capacity");

  // no entry write while the result waits to be loaded
  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != S_EMIT))
    else $error("RAM write in emit state");

  // read data in flight only during a scan
  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    data_vld_r |-> (state_r == S_SCAN))
    else $error("read data pending outside scan");

  // the count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + IW'(1) ||
                                 cnt_r == $past(cnt_r) - IW'(1)))
    else $error("entry count jumped");

endmodule
